### rtl/core/tcfs_pkg.sv
// Shared types, constants and codes of the timed cue fire scheduler.
package tcfs_pkg;

    localparam int NUM_PINS_DEF = 64;
    localparam int TIME_W       = 32;
    localparam int PULSE_W      = 16;
    localparam int PIN_OUT_W    = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic               RUN_ENABLE_RST = 1'b0;
    localparam logic [PULSE_W-1:0] FIRE_PULSE_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE = 1'd0,
        CFG_FIRE_PULSE = 1'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_LOAD    = 2'd1,
        KIND_SYNC    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic              armed;
        logic [5:0]        pin_index;
        logic [TIME_W-1:0] time_value;
    } t_item;

    typedef struct packed {
        logic                 fire_drive;
        logic                 fired_now;
        logic [PIN_OUT_W-1:0] selected_pin;
        logic [TIME_W-1:0]    show_clock;
    } t_result;

    // Commands from the sequencer to the fire-time table.
    typedef struct packed {
        logic load;
        logic clear_flags;
        logic scan_start;
        logic scan_step;
    } t_tbl_cmd;

    // Scan status back from the table.
    typedef struct packed {
        logic hit;
        logic done;
    } t_tbl_stat;

endpackage

### rtl/core/tcfs_stream_if.sv
// Valid/ready stream interface used for the item and result channels.
interface tcfs_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/tcfs_fire_table.sv
// Fire-time memory, fired flags and the one-entry-per-cycle due-time scan.
module tcfs_fire_table #(
    parameter int NUM_PINS = tcfs_pkg::NUM_PINS_DEF,
    parameter int PIN_W    = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcfs_pkg::t_tbl_cmd        i_cmd,
    input  logic [PIN_W-1:0]          i_load_addr,
    input  logic [tcfs_pkg::TIME_W-1:0] i_load_data,
    input  logic [tcfs_pkg::TIME_W-1:0] i_show_time,
    output tcfs_pkg::t_tbl_stat       o_stat,
    output logic [PIN_W-1:0]          o_hit_idx
);
    localparam int CNT_W = $clog2(NUM_PINS + 1);

    logic [tcfs_pkg::TIME_W-1:0] r_mem [NUM_PINS];
    logic [tcfs_pkg::TIME_W-1:0] r_rd_data;
    logic [NUM_PINS-1:0]         r_fired;
    logic [CNT_W-1:0]            r_rd_idx;
    logic [PIN_W-1:0]            r_cmp_idx;
    logic                        r_cmp_valid;
    logic                        w_rd_ok;
    logic                        w_hit;
    logic                        w_last;

    assign w_rd_ok = (r_rd_idx < CNT_W'(NUM_PINS));
    assign w_hit   = r_cmp_valid && !r_fired[r_cmp_idx] && (i_show_time >= r_rd_data);
    assign w_last  = (r_cmp_idx == PIN_W'(NUM_PINS - 1));

    assign o_stat.hit  = w_hit;
    assign o_stat.done = r_cmp_valid && w_last && !w_hit;
    assign o_hit_idx   = r_cmp_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_load_addr] <= i_load_data;
        end
        if (i_cmd.scan_step && w_rd_ok) begin
            r_rd_data <= r_mem[r_rd_idx[PIN_W-1:0]];
        end
    end

    // Read address runs one entry ahead of the compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_cmp_idx   <= '0;
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_valid <= w_rd_ok;
            r_cmp_idx   <= r_rd_idx[PIN_W-1:0];
            if (w_rd_ok) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fired <= '0;
        end else if (i_cmd.clear_flags) begin
            r_fired <= '0;
        end else if (i_cmd.scan_step && w_hit) begin
            r_fired[r_cmp_idx] <= 1'b1;
        end
    end

endmodule

### rtl/core/timed_cue_fire_scheduler.sv
// Top level of the timed cue fire scheduler: sequencer, show clock and pulse state.
//
// Each accepted transaction returns exactly one result. Loads, syncs, restarts and ticks
// that need no cue search go from acceptance through the result state to the result
// register. A tick that searches for a due cue (running, armed and no pulse in progress)
// walks the fire-time memory one pin per cycle through its single registered read port and
// stops at the first due pin, or after the last pin when none is due. A new transaction
// is taken only when the previous one has been written to the result register; the result
// may still be waiting downstream at that point. Configuration is written through a plain
// write port (index 0 run enable, index 1 fire pulse length in ticks). Fire times are
// undefined until loaded and every pin in the scan range must be loaded before a search.
module timed_cue_fire_scheduler #(
    parameter int NUM_PINS = tcfs_pkg::NUM_PINS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcfs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    tcfs_stream_if.sink                       i_item,
    tcfs_stream_if.source                     o_result
);
    localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    tcfs_pkg::t_state r_state;
    tcfs_pkg::t_state n_state;

    logic                            r_run_enable;
    logic [tcfs_pkg::PULSE_W-1:0]    r_fire_pulse;
    logic [tcfs_pkg::TIME_W-1:0]     r_show_time;
    logic [tcfs_pkg::PULSE_W-1:0]    r_pulse_left;
    logic                            r_pulse_active;
    logic [tcfs_pkg::PIN_OUT_W-1:0]  r_last_pin;
    logic                            r_fired;
    logic                            r_out_valid;
    tcfs_pkg::t_result               r_res;

    tcfs_pkg::t_item     w_item;
    tcfs_pkg::t_tbl_cmd  w_cmd;
    tcfs_pkg::t_tbl_stat w_stat;
    logic [PIN_W-1:0]    w_hit_idx;
    logic                w_accept;
    logic                w_scan_tick;
    logic                w_load_ok;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_add_sync;
    logic [tcfs_pkg::TIME_W-1:0] w_add_b;
    logic [tcfs_pkg::TIME_W:0]   w_sum;

    assign w_item      = i_item.payload;
    assign w_accept    = i_item.valid && i_item.ready;
    assign w_scan_tick = (w_item.kind == tcfs_pkg::KIND_TICK) && r_run_enable
                         && !r_pulse_active && w_item.armed;
    assign w_load_ok   = (int'(w_item.pin_index) < NUM_PINS);
    assign w_out_free  = !r_out_valid || o_result.ready;

    // Shared 33-bit adder: plus one for ticks, averaging sum for syncs.
    assign w_add_sync = w_accept && (w_item.kind == tcfs_pkg::KIND_SYNC);
    assign w_add_b    = w_add_sync ? w_item.time_value : tcfs_pkg::TIME_W'(1);
    assign w_sum      = {1'b0, r_show_time} + {1'b0, w_add_b};

    tcfs_fire_table #(
        .NUM_PINS (NUM_PINS),
        .PIN_W    (PIN_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_load_addr (PIN_W'(w_item.pin_index)),
        .i_load_data (w_item.time_value),
        .i_show_time (r_show_time),
        .o_stat      (w_stat),
        .o_hit_idx   (w_hit_idx)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcfs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_scan_tick ? tcfs_pkg::ST_SCAN : tcfs_pkg::ST_RESULT;
                end
            end
            tcfs_pkg::ST_SCAN: begin
                if (w_stat.hit || w_stat.done) begin
                    n_state = tcfs_pkg::ST_RESULT;
                end
            end
            tcfs_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = tcfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_item.ready      = 1'b0;
        w_cmd             = '0;
        w_out_load        = 1'b0;
        case (r_state)
            tcfs_pkg::ST_IDLE: begin
                i_item.ready      = 1'b1;
                w_cmd.load        = w_accept && (w_item.kind == tcfs_pkg::KIND_LOAD) && w_load_ok;
                w_cmd.clear_flags = w_accept && (w_item.kind == tcfs_pkg::KIND_RESTART);
                w_cmd.scan_start  = w_accept && w_scan_tick;
            end
            tcfs_pkg::ST_SCAN: begin
                w_cmd.scan_step = 1'b1;
            end
            tcfs_pkg::ST_RESULT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= tcfs_pkg::RUN_ENABLE_RST;
            r_fire_pulse <= tcfs_pkg::FIRE_PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcfs_pkg::CFG_RUN_ENABLE: r_run_enable <= i_cfg_wdata[0];
                tcfs_pkg::CFG_FIRE_PULSE: r_fire_pulse <= i_cfg_wdata[tcfs_pkg::PULSE_W-1:0];
                default: r_run_enable <= r_run_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_time    <= '0;
            r_pulse_left   <= '0;
            r_pulse_active <= 1'b0;
            r_last_pin     <= '0;
            r_fired        <= 1'b0;
        end else if (w_accept) begin
            r_fired <= 1'b0;
            case (w_item.kind)
                tcfs_pkg::KIND_TICK: begin
                    // A searching tick advances the clock only once the search ends.
                    if (!w_scan_tick) begin
                        r_show_time <= w_sum[tcfs_pkg::TIME_W-1:0];
                        if (r_run_enable && r_pulse_active) begin
                            r_pulse_left <= r_pulse_left - tcfs_pkg::PULSE_W'(1);
                            if (r_pulse_left == tcfs_pkg::PULSE_W'(1)) begin
                                r_pulse_active <= 1'b0;
                            end
                        end
                    end
                end
                tcfs_pkg::KIND_SYNC: begin
                    r_show_time <= w_sum[tcfs_pkg::TIME_W:1];
                end
                tcfs_pkg::KIND_RESTART: begin
                    r_show_time    <= '0;
                    r_pulse_left   <= '0;
                    r_pulse_active <= 1'b0;
                end
                default: begin
                    r_fired <= 1'b0;
                end
            endcase
        end else if (w_cmd.scan_step && (w_stat.hit || w_stat.done)) begin
            r_show_time <= w_sum[tcfs_pkg::TIME_W-1:0];
            if (w_stat.hit) begin
                r_pulse_active <= 1'b1;
                r_pulse_left   <= r_fire_pulse;
                r_last_pin     <= tcfs_pkg::PIN_OUT_W'(w_hit_idx);
                r_fired        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_res.fire_drive   <= r_pulse_active;
            r_res.fired_now    <= r_fired;
            r_res.selected_pin <= r_last_pin;
            r_res.show_clock   <= r_show_time;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_res;

`ifndef SYNTH
    a_fire_sets_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.payload.fired_now) |-> o_result.payload.fire_drive)
        else $error("result reports a fired cue without the fire drive");

    a_restart_clears_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_item.kind == tcfs_pkg::KIND_RESTART))
        |=> (r_show_time == '0) && !r_pulse_active)
        else $error("restart did not clear the show clock and pulse");

    a_hit_starts_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tcfs_pkg::ST_SCAN) && w_stat.hit)
        |=> r_pulse_active && r_fired && (r_state == tcfs_pkg::ST_RESULT))
        else $error("scan hit did not start a fire pulse");
`endif

endmodule
